// ===== rtl/core/evad_pkg.sv =====
// ----------------------------------------------------------------------------
// evad_pkg
// Shared types, constants and helpers of the energy endpoint detector.
// ----------------------------------------------------------------------------
package evad_pkg;

  localparam int unsigned ENERGY_W  = 43;
  localparam int unsigned SQ_W      = 31;
  localparam int unsigned COUNT_W   = 21;
  localparam int unsigned LIMIT_W   = 20;
  localparam int unsigned THRESH_W  = 31;
  localparam int unsigned Q_DEPTH   = 4;
  localparam int unsigned Q_PTR_W   = 2;
  localparam int unsigned Q_CNT_W   = 3;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam logic [ENERGY_W-1:0] ENERGY_MAX = {ENERGY_W{1'b1}};
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};

  localparam logic [1:0] REG_THRESHOLD    = 2'd0;
  localparam logic [1:0] REG_LEAD_LIMIT   = 2'd1;
  localparam logic [1:0] REG_TRAIL_LIMIT  = 2'd2;
  localparam logic [1:0] REG_SPEECH_LIMIT = 2'd3;

  localparam logic [THRESH_W-1:0] THRESHOLD_RESET    = 31'd0;
  localparam logic [LIMIT_W-1:0]  LEAD_LIMIT_RESET   = 20'd81920;
  localparam logic [LIMIT_W-1:0]  TRAIL_LIMIT_RESET  = 20'd8192;
  localparam logic [LIMIT_W-1:0]  SPEECH_LIMIT_RESET = 20'd240000;

  localparam logic [1:0] END_NONE      = 2'd0;
  localparam logic [1:0] END_NO_SPEECH = 2'd1;
  localparam logic [1:0] END_TRAIL     = 2'd2;
  localparam logic [1:0] END_LENGTH    = 2'd3;

  typedef struct packed {
    logic [THRESH_W-1:0] energy_threshold;
    logic [LIMIT_W-1:0]  lead_silence_limit;
    logic [LIMIT_W-1:0]  trail_silence_limit;
    logic [LIMIT_W-1:0]  speech_length_limit;
  } evad_cfg_t;

  typedef struct packed {
    logic       voiced;
    logic       session_begin;
    logic       buffer_clear;
    logic       frame_keep;
    logic       upload_start;
    logic       drop_last_frame;
    logic       session_end;
    logic [1:0] end_reason;
  } evad_result_t;

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
  endfunction

endpackage

// ===== rtl/core/energy_vad_endpoint_detector_top.sv =====
// ----------------------------------------------------------------------------
// energy_vad_endpoint_detector_top
// Energy voice activity endpoint detector with APB configuration registers.
// ----------------------------------------------------------------------------
// Result path: sample register, frame queue, judge register, output register.
// Throughput: one request per cycle; input stalls only while the output is
// stalled and the 4-entry frame queue behind the sample stage has filled.
// Reset: synchronous; clears accumulator, queue, session state and output,
// and returns registers to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module energy_vad_endpoint_detector_top #(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [evad_pkg::ADDR_W-1:0] paddr,
  input  logic [evad_pkg::DATA_W-1:0] pwdata,
  output logic [evad_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        kind,
  input  logic signed [15:0]          sample,
  input  logic                        frame_last,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        voiced,
  output logic                        session_begin,
  output logic                        buffer_clear,
  output logic                        frame_keep,
  output logic                        upload_start,
  output logic                        drop_last_frame,
  output logic                        session_end,
  output logic [1:0]                  end_reason
);

  localparam int unsigned CW = $clog2(MAX_FRAME_SAMPLES + 1);

  evad_pkg::evad_cfg_t           cfg;
  evad_pkg::evad_result_t        out_res;
  logic [1:0]                    reg_idx;
  logic                          wr_en;
  logic [evad_pkg::Q_CNT_W-1:0]  q_count;
  logic                          push;
  logic                          push_restart;
  logic [evad_pkg::ENERGY_W-1:0] push_energy;
  logic [CW-1:0]                 push_n;
  logic                          pop;
  logic                          head_valid;
  logic                          head_restart;
  logic [evad_pkg::ENERGY_W-1:0] head_energy;
  logic [CW-1:0]                 head_n;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.energy_threshold    <= evad_pkg::THRESHOLD_RESET;
      cfg.lead_silence_limit  <= evad_pkg::LEAD_LIMIT_RESET;
      cfg.trail_silence_limit <= evad_pkg::TRAIL_LIMIT_RESET;
      cfg.speech_length_limit <= evad_pkg::SPEECH_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        evad_pkg::REG_THRESHOLD:
          cfg.energy_threshold <= pwdata[evad_pkg::THRESH_W-1:0];
        evad_pkg::REG_LEAD_LIMIT:
          cfg.lead_silence_limit <= pwdata[evad_pkg::LIMIT_W-1:0];
        evad_pkg::REG_TRAIL_LIMIT:
          cfg.trail_silence_limit <= pwdata[evad_pkg::LIMIT_W-1:0];
        evad_pkg::REG_SPEECH_LIMIT:
          cfg.speech_length_limit <= pwdata[evad_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      evad_pkg::REG_THRESHOLD:    prdata = evad_pkg::DATA_W'(cfg.energy_threshold);
      evad_pkg::REG_LEAD_LIMIT:   prdata = evad_pkg::DATA_W'(cfg.lead_silence_limit);
      evad_pkg::REG_TRAIL_LIMIT:  prdata = evad_pkg::DATA_W'(cfg.trail_silence_limit);
      evad_pkg::REG_SPEECH_LIMIT: prdata = evad_pkg::DATA_W'(cfg.speech_length_limit);
      default:                    prdata = '0;
    endcase
  end

  evad_front #(
    .MAX_FRAME_SAMPLES(MAX_FRAME_SAMPLES),
    .CW(CW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .sample(sample),
    .frame_last(frame_last),
    .q_count(q_count),
    .push(push),
    .push_restart(push_restart),
    .push_energy(push_energy),
    .push_n(push_n)
  );

  evad_queue #(
    .CW(CW)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_restart(push_restart),
    .push_energy(push_energy),
    .push_n(push_n),
    .pop(pop),
    .head_valid(head_valid),
    .head_restart(head_restart),
    .head_energy(head_energy),
    .head_n(head_n),
    .count(q_count)
  );

  evad_back #(
    .CW(CW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .cfg(cfg),
    .head_valid(head_valid),
    .head_restart(head_restart),
    .head_energy(head_energy),
    .head_n(head_n),
    .pop(pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res(out_res)
  );

  assign voiced          = out_res.voiced;
  assign session_begin   = out_res.session_begin;
  assign buffer_clear    = out_res.buffer_clear;
  assign frame_keep      = out_res.frame_keep;
  assign upload_start    = out_res.upload_start;
  assign drop_last_frame = out_res.drop_last_frame;
  assign session_end     = out_res.session_end;
  assign end_reason      = out_res.end_reason;

endmodule

// ===== rtl/core/evad_front.sv =====
// ----------------------------------------------------------------------------
// evad_front
// Squares samples, accumulates frame energy and posts frame records.
// ----------------------------------------------------------------------------
module evad_front #(
  parameter int unsigned MAX_FRAME_SAMPLES = 4096,
  parameter int unsigned CW = $clog2(MAX_FRAME_SAMPLES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          kind,
  input  logic signed [15:0]            sample,
  input  logic                          frame_last,
  input  logic [evad_pkg::Q_CNT_W-1:0]  q_count,
  output logic                          push,
  output logic                          push_restart,
  output logic [evad_pkg::ENERGY_W-1:0] push_energy,
  output logic [CW-1:0]                 push_n
);

  logic                        a_valid;
  logic                        a_kind;
  logic                        a_last;
  logic [evad_pkg::SQ_W-1:0]   a_sq;
  logic [evad_pkg::ENERGY_W-1:0] acc;
  logic [evad_pkg::ENERGY_W-1:0] acc_next;
  logic [CW-1:0]               cnt;
  logic [CW-1:0]               cnt_next;
  logic [15:0]                 mag;
  logic [31:0]                 sq_full;
  logic [evad_pkg::ENERGY_W:0] sum;
  logic                        accept;

  assign in_stall = ({1'b0, q_count} + {{evad_pkg::Q_CNT_W{1'b0}}, a_valid})
                    >= (evad_pkg::Q_CNT_W + 1)'(evad_pkg::Q_DEPTH);
  assign accept   = in_valid && !in_stall;

  assign mag     = sample[15] ? 16'(-sample) : 16'(sample);
  assign sq_full = {16'd0, mag} * {16'd0, mag};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
    if (accept) begin
      a_kind <= kind;
      a_last <= frame_last;
      a_sq   <= sq_full[evad_pkg::SQ_W-1:0];
    end
  end

  always_comb begin
    sum          = {1'b0, acc} + (evad_pkg::ENERGY_W + 1)'(a_sq);
    acc_next     = acc;
    cnt_next     = cnt;
    push         = 1'b0;
    push_restart = 1'b0;
    if (a_valid) begin
      if (a_kind) begin
        push         = 1'b1;
        push_restart = 1'b1;
        acc_next     = '0;
        cnt_next     = '0;
      end else begin
        if (cnt < CW'(MAX_FRAME_SAMPLES)) begin
          acc_next = sum[evad_pkg::ENERGY_W] ? evad_pkg::ENERGY_MAX
                                             : sum[evad_pkg::ENERGY_W-1:0];
          cnt_next = cnt + CW'(1);
        end
        if (a_last) begin
          push = 1'b1;
        end
      end
    end
    push_energy = acc_next;
    push_n      = cnt_next;
    if (push) begin
      acc_next = '0;
      cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
    end else begin
      acc <= acc_next;
      cnt <= cnt_next;
    end
  end

  a_no_acc_past_max: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_FRAME_SAMPLES))
    else $error("frame sample count past maximum");

endmodule

// ===== rtl/core/evad_queue.sv =====
// ----------------------------------------------------------------------------
// evad_queue
// Small FIFO of frame records between the front and back.
// ----------------------------------------------------------------------------
module evad_queue #(
  parameter int unsigned CW = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          push_restart,
  input  logic [evad_pkg::ENERGY_W-1:0] push_energy,
  input  logic [CW-1:0]                 push_n,
  input  logic                          pop,
  output logic                          head_valid,
  output logic                          head_restart,
  output logic [evad_pkg::ENERGY_W-1:0] head_energy,
  output logic [CW-1:0]                 head_n,
  output logic [evad_pkg::Q_CNT_W-1:0]  count
);

  logic                          mem_restart [evad_pkg::Q_DEPTH];
  logic [evad_pkg::ENERGY_W-1:0] mem_energy  [evad_pkg::Q_DEPTH];
  logic [CW-1:0]                 mem_n       [evad_pkg::Q_DEPTH];
  logic [evad_pkg::Q_PTR_W-1:0]  wr_ptr;
  logic [evad_pkg::Q_PTR_W-1:0]  rd_ptr;
  logic                          do_pop;

  assign head_valid   = count != '0;
  assign do_pop       = pop && head_valid;
  assign head_restart = mem_restart[rd_ptr];
  assign head_energy  = mem_energy[rd_ptr];
  assign head_n       = mem_n[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_restart[wr_ptr] <= push_restart;
      mem_energy[wr_ptr]  <= push_energy;
      mem_n[wr_ptr]       <= push_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + evad_pkg::Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + evad_pkg::Q_PTR_W'(1);
      end
      count <= count + evad_pkg::Q_CNT_W'(push) - evad_pkg::Q_CNT_W'(do_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count < evad_pkg::Q_CNT_W'(evad_pkg::Q_DEPTH) || do_pop))
    else $error("queue push while full");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= evad_pkg::Q_CNT_W'(evad_pkg::Q_DEPTH))
    else $error("queue count past depth");

endmodule

// ===== rtl/core/evad_back.sv =====
// ----------------------------------------------------------------------------
// evad_back
// Judges frames against the threshold and runs the session endpoint logic.
// ----------------------------------------------------------------------------
module evad_back #(
  parameter int unsigned CW = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  evad_pkg::evad_cfg_t           cfg,
  input  logic                          head_valid,
  input  logic                          head_restart,
  input  logic [evad_pkg::ENERGY_W-1:0] head_energy,
  input  logic [CW-1:0]                 head_n,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output evad_pkg::evad_result_t        out_res
);

  localparam int unsigned PW   = CW + evad_pkg::THRESH_W;
  localparam int unsigned CMPW = (PW > evad_pkg::ENERGY_W) ? PW : evad_pkg::ENERGY_W;

  logic                          b1_valid;
  logic                          b1_restart;
  logic [evad_pkg::ENERGY_W-1:0] b1_energy;
  logic [CW-1:0]                 b1_n;
  logic [PW-1:0]                 b1_prod;
  logic                          out_ready;
  logic                          exec;
  logic                          b1_load;

  logic                          session_active, session_active_next;
  logic                          in_speech, in_speech_next;
  logic                          upload_started, upload_started_next;
  logic [evad_pkg::COUNT_W-1:0]  lead_silence, lead_silence_next;
  logic [evad_pkg::COUNT_W-1:0]  trail_silence, trail_silence_next;
  logic [evad_pkg::COUNT_W-1:0]  speech_total, speech_total_next;
  logic [evad_pkg::COUNT_W-1:0]  n_ext;
  logic                          voiced;
  evad_pkg::evad_result_t        res;

  assign out_ready = !out_valid || !out_stall;
  assign exec      = b1_valid && out_ready;
  assign b1_load   = !b1_valid || exec;
  assign pop       = b1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else if (b1_load) begin
      b1_valid <= head_valid;
    end
    if (b1_load && head_valid) begin
      b1_restart <= head_restart;
      b1_energy  <= head_energy;
      b1_n       <= head_n;
      b1_prod    <= PW'(head_n) * PW'(cfg.energy_threshold);
    end
  end

  assign n_ext  = evad_pkg::COUNT_W'(b1_n);
  assign voiced = CMPW'(b1_energy) > CMPW'(b1_prod);

  always_comb begin
    session_active_next = session_active;
    in_speech_next      = in_speech;
    upload_started_next = upload_started;
    lead_silence_next   = lead_silence;
    trail_silence_next  = trail_silence;
    speech_total_next   = speech_total;
    res                 = '0;
    res.voiced          = voiced;
    if (!session_active) begin
      session_active_next = 1'b1;
      in_speech_next      = 1'b0;
      upload_started_next = 1'b0;
      lead_silence_next   = '0;
      trail_silence_next  = '0;
      speech_total_next   = '0;
      res.session_begin   = 1'b1;
      res.buffer_clear    = 1'b1;
    end
    res.frame_keep = 1'b1;
    if (!in_speech_next) begin
      if (voiced) begin
        in_speech_next = 1'b1;
        if (!upload_started_next) begin
          upload_started_next = 1'b1;
          res.upload_start    = 1'b1;
        end
      end else begin
        res.buffer_clear  = 1'b1;
        lead_silence_next = evad_pkg::sat_add(lead_silence_next, n_ext);
        if (lead_silence_next > evad_pkg::COUNT_W'(cfg.lead_silence_limit)) begin
          res.session_end = 1'b1;
          res.end_reason  = evad_pkg::END_NO_SPEECH;
        end
      end
    end else if (!voiced) begin
      trail_silence_next = evad_pkg::sat_add(trail_silence_next, n_ext);
      if (trail_silence_next > evad_pkg::COUNT_W'(cfg.trail_silence_limit)) begin
        res.drop_last_frame = 1'b1;
        res.session_end     = 1'b1;
        res.end_reason      = evad_pkg::END_TRAIL;
      end
    end else begin
      trail_silence_next = '0;
      speech_total_next  = evad_pkg::sat_add(speech_total_next, n_ext);
      if (speech_total_next > evad_pkg::COUNT_W'(cfg.speech_length_limit)) begin
        res.session_end = 1'b1;
        res.end_reason  = evad_pkg::END_LENGTH;
      end
    end
    if (res.session_end || b1_restart) begin
      session_active_next = 1'b0;
      in_speech_next      = 1'b0;
      upload_started_next = 1'b0;
      lead_silence_next   = '0;
      trail_silence_next  = '0;
      speech_total_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      session_active <= 1'b0;
      in_speech      <= 1'b0;
      upload_started <= 1'b0;
      lead_silence   <= '0;
      trail_silence  <= '0;
      speech_total   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (exec) begin
        session_active <= session_active_next;
        in_speech      <= in_speech_next;
        upload_started <= upload_started_next;
        lead_silence   <= lead_silence_next;
        trail_silence  <= trail_silence_next;
        speech_total   <= speech_total_next;
      end
      if (exec && !b1_restart) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (exec && !b1_restart) begin
      out_res <= res;
    end
  end

  a_reason_matches_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.session_end == (out_res.end_reason != evad_pkg::END_NONE)))
    else $error("end reason disagrees with session end");

  a_drop_ends_session: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.drop_last_frame) |->
      (out_res.session_end && out_res.end_reason == evad_pkg::END_TRAIL))
    else $error("frame drop outside trailing silence end");

  a_upload_needs_voice: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.upload_start) |-> out_res.voiced)
    else $error("upload start on silent frame");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the energy voice activity endpoint detector. A short
// table of directed frames and register writes runs first, then randomized
// capture sessions under many register settings, input idles and output stalls.
// Every frame result is checked field by field: directed rows against their
// table entry, others against an in-bench model of energy and session logic.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned FRAME_CAP   = 4096;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned PHASES      = 12;
  localparam int unsigned PHASE_REQS  = 85;
  localparam int unsigned LONG_FRAME  = 64;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t              what;
    logic [1:0]             reg_idx;
    logic [31:0]            value;
    logic                   kind;
    logic signed [15:0]     sample;
    logic                   last;
    logic                   typed;
    evad_pkg::evad_result_t res;
  } dir_row_t;

  logic                          clk;
  logic                          rst = 1'b1;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [evad_pkg::ADDR_W-1:0]   paddr = '0;
  logic [evad_pkg::DATA_W-1:0]   pwdata = '0;
  logic [evad_pkg::DATA_W-1:0]   prdata;
  logic                          pready;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          kind = 1'b0;
  logic signed [15:0]            sample = '0;
  logic                          frame_last = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          voiced;
  logic                          session_begin;
  logic                          buffer_clear;
  logic                          frame_keep;
  logic                          upload_start;
  logic                          drop_last_frame;
  logic                          session_end;
  logic [1:0]                    end_reason;

  energy_vad_endpoint_detector_top #(
    .MAX_FRAME_SAMPLES(FRAME_CAP)
  ) u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .sample(sample), .frame_last(frame_last),
    .out_valid(out_valid), .out_stall(out_stall),
    .voiced(voiced), .session_begin(session_begin), .buffer_clear(buffer_clear),
    .frame_keep(frame_keep), .upload_start(upload_start),
    .drop_last_frame(drop_last_frame), .session_end(session_end),
    .end_reason(end_reason)
  );

  logic [evad_pkg::THRESH_W-1:0] thr_cfg;
  logic [evad_pkg::LIMIT_W-1:0]  lead_cfg;
  logic [evad_pkg::LIMIT_W-1:0]  trail_cfg;
  logic [evad_pkg::LIMIT_W-1:0]  speech_cfg;

  logic [evad_pkg::ENERGY_W-1:0] frame_energy;
  logic [12:0]                   frame_len;
  logic                          active;
  logic                          talking;
  logic                          uploading;
  logic [evad_pkg::COUNT_W-1:0]  lead_run;
  logic [evad_pkg::COUNT_W-1:0]  trail_run;
  logic [evad_pkg::COUNT_W-1:0]  speech_run;

  evad_pkg::evad_result_t        pending_outcomes[$];
  dir_row_t                      dir_rows[$];
  evad_pkg::evad_result_t        mon_got;
  evad_pkg::evad_result_t        mon_want;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned requests_sent = 0;
  int unsigned restarts_sent = 0;
  int unsigned frames_checked = 0;
  int unsigned ends_by_reason[4] = '{0, 0, 0, 0};

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_outcomes.size());
      $display("energy_vad_endpoint_detector_top verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [evad_pkg::COUNT_W-1:0] count_add(
      input logic [evad_pkg::COUNT_W-1:0] a, input logic [12:0] n);
    logic [evad_pkg::COUNT_W:0] s;
    s = {1'b0, a} + {{(evad_pkg::COUNT_W - 12){1'b0}}, n};
    return (s > evad_pkg::COUNT_MAX) ? evad_pkg::COUNT_MAX : s[evad_pkg::COUNT_W-1:0];
  endfunction

  function automatic void close_session();
    active     = 1'b0;
    talking    = 1'b0;
    uploading  = 1'b0;
    lead_run   = '0;
    trail_run  = '0;
    speech_run = '0;
  endfunction

  function automatic logic judge_request(input logic k, input logic signed [15:0] s,
                                         input logic last,
                                         output evad_pkg::evad_result_t r);
    logic [16:0] mag;
    logic [evad_pkg::ENERGY_W:0] sum;
    logic [12:0] n;
    logic v;
    r = '0;
    if (k) begin
      frame_energy = '0;
      frame_len = '0;
      close_session();
      return 1'b0;
    end
    mag = s[15] ? (17'h10000 - {1'b0, s}) : {1'b0, s};
    if (frame_len < FRAME_CAP) begin
      sum = frame_energy + mag * mag;
      frame_energy = (sum > evad_pkg::ENERGY_MAX) ? evad_pkg::ENERGY_MAX
                                                  : sum[evad_pkg::ENERGY_W-1:0];
      frame_len++;
    end
    if (!last) return 1'b0;
    n = frame_len;
    v = 64'(frame_energy) > 64'(n) * 64'(thr_cfg);
    frame_energy = '0;
    frame_len = '0;
    r.voiced = v;
    if (!active) begin
      close_session();
      active = 1'b1;
      r.session_begin = 1'b1;
      r.buffer_clear = 1'b1;
    end
    r.frame_keep = 1'b1;
    if (!talking) begin
      if (v) begin
        talking = 1'b1;
        if (!uploading) begin
          uploading = 1'b1;
          r.upload_start = 1'b1;
        end
      end else begin
        r.buffer_clear = 1'b1;
        lead_run = count_add(lead_run, n);
        if (lead_run > lead_cfg) begin
          r.session_end = 1'b1;
          r.end_reason = evad_pkg::END_NO_SPEECH;
          close_session();
        end
      end
    end else if (!v) begin
      trail_run = count_add(trail_run, n);
      if (trail_run > trail_cfg) begin
        r.drop_last_frame = 1'b1;
        r.session_end = 1'b1;
        r.end_reason = evad_pkg::END_TRAIL;
        close_session();
      end
    end else begin
      trail_run = '0;
      speech_run = count_add(speech_run, n);
      if (speech_run > speech_cfg) begin
        r.session_end = 1'b1;
        r.end_reason = evad_pkg::END_LENGTH;
        close_session();
      end
    end
    return 1'b1;
  endfunction

  function automatic evad_pkg::evad_result_t outcome(input logic v, input logic sb,
                                                     input logic bc, input logic keep,
                                                     input logic us, input logic dr,
                                                     input logic se,
                                                     input logic [1:0] reason);
    return {v, sb, bc, keep, us, dr, se, reason};
  endfunction

  function automatic void dir_item(input logic k, input logic signed [15:0] s,
                                   input logic last, input logic typed,
                                   input evad_pkg::evad_result_t res);
    dir_row_t row;
    row.what = ROW_ITEM;
    row.reg_idx = '0;
    row.value = '0;
    row.kind = k;
    row.sample = s;
    row.last = last;
    row.typed = typed;
    row.res = res;
    dir_rows.push_back(row);
  endfunction

  function automatic void dir_cfg(input logic [1:0] idx, input logic [31:0] value);
    dir_row_t row;
    row.what = ROW_CFG;
    row.reg_idx = idx;
    row.value = value;
    row.kind = 1'b0;
    row.sample = '0;
    row.last = 1'b0;
    row.typed = 1'b0;
    row.res = '0;
    dir_rows.push_back(row);
  endfunction

  function automatic int field_bad(input string name, input logic [1:0] e,
                                   input logic [1:0] a);
    if (e === a) return 0;
    $display("%0t ns: frame result %0d, %s expected %0d actual %0d", $time,
             frames_checked, name, e, a);
    return 1;
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      mon_got = {voiced, session_begin, buffer_clear, frame_keep, upload_start,
                 drop_last_frame, session_end, end_reason};
      if (pending_outcomes.size() == 0) begin
        $display("%0t ns: unexpected frame result, expected none, actual %b", $time,
                 mon_got);
        errors++;
      end else begin
        mon_want = pending_outcomes.pop_front();
        errors += field_bad("voiced", {1'b0, mon_want.voiced}, {1'b0, mon_got.voiced});
        errors += field_bad("session_begin", {1'b0, mon_want.session_begin},
                            {1'b0, mon_got.session_begin});
        errors += field_bad("buffer_clear", {1'b0, mon_want.buffer_clear},
                            {1'b0, mon_got.buffer_clear});
        errors += field_bad("frame_keep", {1'b0, mon_want.frame_keep},
                            {1'b0, mon_got.frame_keep});
        errors += field_bad("upload_start", {1'b0, mon_want.upload_start},
                            {1'b0, mon_got.upload_start});
        errors += field_bad("drop_last_frame", {1'b0, mon_want.drop_last_frame},
                            {1'b0, mon_got.drop_last_frame});
        errors += field_bad("session_end", {1'b0, mon_want.session_end},
                            {1'b0, mon_got.session_end});
        errors += field_bad("end_reason", mon_want.end_reason, mon_got.end_reason);
        if (mon_want.session_end) ends_by_reason[mon_want.end_reason]++;
        frames_checked++;
      end
    end
  end

  task automatic send_request(input logic k, input logic signed [15:0] s,
                              input logic last, input logic typed,
                              input evad_pkg::evad_result_t want);
    evad_pkg::evad_result_t pred;
    logic has;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    sample <= s;
    frame_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has = judge_request(k, s, last, pred);
    if (has) pending_outcomes.push_back(typed ? want : pred);
    requests_sent++;
    if (k) restarts_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] kept;
    kept = (idx == evad_pkg::REG_THRESHOLD) ? (value & 32'h7FFF_FFFF)
                                            : (value & 32'h000F_FFFF);
    case (idx)
      evad_pkg::REG_THRESHOLD:   thr_cfg = kept[evad_pkg::THRESH_W-1:0];
      evad_pkg::REG_LEAD_LIMIT:  lead_cfg = kept[evad_pkg::LIMIT_W-1:0];
      evad_pkg::REG_TRAIL_LIMIT: trail_cfg = kept[evad_pkg::LIMIT_W-1:0];
      default:                   speech_cfg = kept[evad_pkg::LIMIT_W-1:0];
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== kept) begin
      $display("%0t ns: register %0d readback expected %0h actual %0h", $time, idx,
               kept, prdata);
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_threshold();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 32'd0;
    if (r < 20) return 32'h4000_0000;
    if (r < 30) return $urandom;
    if (r < 40) return $urandom_range(0, 32'h4000_0000);
    return $urandom_range(100, 20000);
  endfunction

  function automatic logic [31:0] pick_limit();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return 32'd0;
    if (r < 20) return 32'h000F_FFFF;
    if (r < 30) return $urandom;
    return $urandom_range(0, 96);
  endfunction

  task automatic send_frame();
    int unsigned r;
    int unsigned len;
    int unsigned style;
    int unsigned cut;
    logic signed [15:0] s;
    r = $urandom_range(99);
    len = (r < 85) ? $urandom_range(1, 8) : (r < 97) ? $urandom_range(9, 40)
        : $urandom_range(41, 200);
    style = $urandom_range(2);
    cut = ($urandom_range(99) < 4) ? $urandom_range(1, len) : 0;
    for (int unsigned i = 1; i <= len; i++) begin
      if (i == cut) send_request(1'b1, 16'($urandom), 1'($urandom), 1'b0, '0);
      case (style)
        0:       s = 16'($urandom_range(0, 60));
        1:       s = 16'($urandom_range(2000, 32767));
        default: s = 16'($urandom);
      endcase
      if (style != 2 && $urandom_range(1)) s = -s;
      send_request(1'b0, s, i == len, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned target;
    logic paused;
    thr_cfg = evad_pkg::THRESHOLD_RESET;
    lead_cfg = evad_pkg::LEAD_LIMIT_RESET;
    trail_cfg = evad_pkg::TRAIL_LIMIT_RESET;
    speech_cfg = evad_pkg::SPEECH_LIMIT_RESET;
    frame_energy = '0;
    frame_len = '0;
    close_session();
    paused = 1'b0;

    dir_item(1'b0, 16'sd0, 1'b0, 1'b0, '0);
    dir_item(1'b0, 16'sd0, 1'b1, 1'b1, outcome(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
             1'b0, evad_pkg::END_NONE));
    dir_item(1'b0, 16'sd32767, 1'b1, 1'b1, outcome(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
             1'b0, evad_pkg::END_NONE));
    dir_item(1'b0, 16'sh8000, 1'b1, 1'b1, outcome(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
             1'b0, evad_pkg::END_NONE));
    dir_item(1'b0, 16'sd0, 1'b1, 1'b1, outcome(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
             1'b0, evad_pkg::END_NONE));
    dir_item(1'b1, -16'sd1, 1'b1, 1'b0, '0);
    dir_item(1'b0, -16'sd1, 1'b1, 1'b1, outcome(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
             1'b0, evad_pkg::END_NONE));
    dir_cfg(evad_pkg::REG_LEAD_LIMIT, 32'd0);
    dir_item(1'b1, 16'sd0, 1'b0, 1'b0, '0);
    dir_item(1'b0, 16'sd0, 1'b1, 1'b1, outcome(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
             1'b1, evad_pkg::END_NO_SPEECH));
    dir_cfg(evad_pkg::REG_TRAIL_LIMIT, 32'd0);
    dir_item(1'b0, 16'sd100, 1'b1, 1'b1, outcome(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
             1'b0, evad_pkg::END_NONE));
    dir_item(1'b0, 16'sd0, 1'b1, 1'b1, outcome(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1,
             1'b1, evad_pkg::END_TRAIL));
    dir_cfg(evad_pkg::REG_SPEECH_LIMIT, 32'd0);
    dir_item(1'b0, 16'sd5, 1'b1, 1'b1, outcome(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
             1'b0, evad_pkg::END_NONE));
    dir_item(1'b0, 16'sd5, 1'b1, 1'b1, outcome(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
             1'b1, evad_pkg::END_LENGTH));
    dir_cfg(evad_pkg::REG_THRESHOLD, 32'h4000_0000);
    dir_item(1'b0, 16'sh8000, 1'b1, 1'b1, outcome(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
             1'b1, evad_pkg::END_NO_SPEECH));
    dir_cfg(evad_pkg::REG_LEAD_LIMIT, 32'h000F_FFFF);
    dir_item(1'b0, 16'sd7, 1'b0, 1'b0, '0);
    dir_item(1'b0, 16'sh8000, 1'b1, 1'b1, outcome(1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
             1'b0, evad_pkg::END_NONE));
    dir_item(1'b0, 16'sd32767, 1'b0, 1'b0, '0);
    dir_item(1'b0, 16'sd32767, 1'b1, 1'b1, outcome(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
             1'b0, evad_pkg::END_NONE));
    dir_item(1'b1, 16'sd0, 1'b0, 1'b0, '0);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].what == ROW_CFG) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].value);
      end else begin
        send_request(dir_rows[i].kind, dir_rows[i].sample, dir_rows[i].last,
                     dir_rows[i].typed, dir_rows[i].res);
      end
    end
    settle();

    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      case (p)
        0: begin
          write_reg(evad_pkg::REG_THRESHOLD, 32'd1000);
          write_reg(evad_pkg::REG_LEAD_LIMIT, 32'd40);
          write_reg(evad_pkg::REG_TRAIL_LIMIT, 32'd20);
          write_reg(evad_pkg::REG_SPEECH_LIMIT, 32'd60);
        end
        1: begin
          write_reg(evad_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
          write_reg(evad_pkg::REG_LEAD_LIMIT, 32'd12);
          write_reg(evad_pkg::REG_TRAIL_LIMIT, 32'd0);
          write_reg(evad_pkg::REG_SPEECH_LIMIT, 32'd0);
        end
        2: begin
          write_reg(evad_pkg::REG_THRESHOLD, 32'd0);
          write_reg(evad_pkg::REG_LEAD_LIMIT, 32'd0);
          write_reg(evad_pkg::REG_TRAIL_LIMIT, 32'hFFFF_FFFF);
          write_reg(evad_pkg::REG_SPEECH_LIMIT, 32'h000F_FFFF);
        end
        default: begin
          write_reg(evad_pkg::REG_THRESHOLD, pick_threshold());
          write_reg(evad_pkg::REG_LEAD_LIMIT, pick_limit());
          write_reg(evad_pkg::REG_TRAIL_LIMIT, pick_limit());
          write_reg(evad_pkg::REG_SPEECH_LIMIT, pick_limit());
        end
      endcase
      target = requests_sent + PHASE_REQS;
      while (requests_sent < target) begin
        if ($urandom_range(99) < 3)
          send_request(1'b1, 16'($urandom), 1'($urandom), 1'b0, '0);
        else
          send_frame();
        // hold off until the result queue runs dry
        if (p == 6 && !paused && requests_sent + PHASE_REQS / 2 >= target) begin
          settle();
          paused = 1'b1;
        end
      end
      settle();
    end

    idle_pct = 0;
    stall_pct = 0;
    write_reg(evad_pkg::REG_THRESHOLD, 32'h4000_0000);
    write_reg(evad_pkg::REG_LEAD_LIMIT, 32'h000F_FFFF);
    write_reg(evad_pkg::REG_TRAIL_LIMIT, 32'h000F_FFFF);
    write_reg(evad_pkg::REG_SPEECH_LIMIT, 32'h000F_FFFF);
    for (int unsigned i = 1; i <= LONG_FRAME; i++)
      send_request(1'b0, 16'sh8000, i == LONG_FRAME, 1'b0, '0);
    repeat (10) send_frame();
    settle();

    $display("Checked %0d frame results from %0d requests (%0d restarts) across %0d",
             frames_checked, requests_sent, restarts_sent, PHASES + 1);
    $display("register settings; sessions closed: %0d no speech, %0d trailing %s",
             ends_by_reason[evad_pkg::END_NO_SPEECH], ends_by_reason[evad_pkg::END_TRAIL],
             $sformatf("silence, %0d length limit.",
                       ends_by_reason[evad_pkg::END_LENGTH]));
    if (errors == 0 && pending_outcomes.size() == 0) begin
      $display("energy_vad_endpoint_detector_top verification clean");
    end else begin
      $display("energy_vad_endpoint_detector_top verification failed");
    end
    $finish;
  end

endmodule
